// File: rtl/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and helper functions for the Cartesian to spherical
// point converter: output widths, fixed-point formats, arctangent table.
// ----------------------------------------------------------------------------
package c2s_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF = 20;
    localparam int ANGLE_FRAC_DEF = 8;

    // fixed output field widths
    localparam int RANGE_WIDTH     = 20;
    localparam int AZIMUTH_WIDTH   = 17;
    localparam int ELEVATION_WIDTH = 16;

    // internal formats
    localparam int INT_FRAC     = 20;               // angle fraction bits, degrees
    localparam int CORDIC_STEPS = 24;
    localparam int NORM_BITS    = 31;               // normalized magnitude length
    localparam int NORM_W       = NORM_BITS + 1;    // normalized operand width
    localparam int SQ_W         = 2 * NORM_W;       // radicand width
    localparam int ROOT_W       = SQ_W / 2;
    localparam int CX_W         = NORM_W + 4;       // CORDIC x/y datapath
    localparam int ANG_W        = INT_FRAC + 10;    // CORDIC angle datapath
    localparam int LEN_W        = $clog2(NORM_W + 1);
    localparam int SHIFT_W      = $clog2(NORM_W);

    localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(94371840);   // 90 << 20
    localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(188743680);  // 180 << 20

    // atan(2^-i) in degrees, Q.20, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_q20(input int step);
        logic [ANG_W-1:0] v;
        case (step)
            0:  v = ANG_W'(47185920);
            1:  v = ANG_W'(27855475);
            2:  v = ANG_W'(14718068);
            3:  v = ANG_W'(7471121);
            4:  v = ANG_W'(3750058);
            5:  v = ANG_W'(1876857);
            6:  v = ANG_W'(938658);
            7:  v = ANG_W'(469357);
            8:  v = ANG_W'(234682);
            9:  v = ANG_W'(117342);
            10: v = ANG_W'(58671);
            11: v = ANG_W'(29335);
            12: v = ANG_W'(14668);
            13: v = ANG_W'(7334);
            14: v = ANG_W'(3667);
            15: v = ANG_W'(1833);
            16: v = ANG_W'(917);
            17: v = ANG_W'(458);
            18: v = ANG_W'(229);
            19: v = ANG_W'(115);
            20: v = ANG_W'(57);
            21: v = ANG_W'(29);
            22: v = ANG_W'(14);
            23: v = ANG_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // number of significant bits (priority encode)
    function automatic logic [LEN_W-1:0] bit_len(input logic [NORM_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < NORM_W; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // left shift that brings the magnitude to NORM_BITS bits
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [LEN_W-1:0] len);
        logic [SHIFT_W-1:0] s;
        if (len < LEN_W'(NORM_BITS)) begin
            s = SHIFT_W'(LEN_W'(NORM_BITS) - len);
        end else begin
            s = '0;
        end
        return s;
    endfunction

endpackage

// File: rtl/c2s_front.sv
// ----------------------------------------------------------------------------
// c2s_front
// Input stage: takes points, splits each coordinate into sign and magnitude,
// finds the largest magnitudes, and queues the item for the back end.
// ----------------------------------------------------------------------------
module c2s_front #(
    parameter int COORD_BITS = c2s_pkg::COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_x_mm,
    input  logic signed [COORD_BITS-1:0] s_y_mm,
    input  logic signed [COORD_BITS-1:0] s_z_mm,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [COORD_BITS-1:0]        q_ax,
    output logic [COORD_BITS-1:0]        q_ay,
    output logic [COORD_BITS-1:0]        q_az,
    output logic [COORD_BITS-1:0]        q_mxy,
    output logic [COORD_BITS-1:0]        q_mall,
    output logic [2:0]                   q_neg
);
    import c2s_pkg::*;

    localparam int QW = 5 * COORD_BITS + 3;
    localparam logic [1:0] Q_FULL = 2'd2;

    function automatic logic [COORD_BITS-1:0] mag(input logic [COORD_BITS-1:0] v);
        return v[COORD_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // classify stage
    logic                  f_valid_reg, f_valid_next;
    logic [COORD_BITS-1:0] f_ax_reg, f_ay_reg, f_az_reg;
    logic [2:0]            f_neg_reg;

    // two-entry queue
    logic [QW-1:0] q_mem_reg [0:1];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    logic                  push, pop, s_accept;
    logic [COORD_BITS-1:0] mxy, mall;
    logic [QW-1:0]         q_word;

    assign pop      = q_valid && q_ready;
    assign push     = f_valid_reg && ((count_reg != Q_FULL) || pop);
    assign s_ready  = !f_valid_reg || push;
    assign s_accept = s_valid && s_ready;

    // largest magnitudes for normalization
    always_comb begin
        mxy  = (f_ax_reg > f_ay_reg) ? f_ax_reg : f_ay_reg;
        mall = (mxy > f_az_reg) ? mxy : f_az_reg;
    end

    assign q_valid = (count_reg != 2'd0);
    assign q_word  = q_mem_reg[rd_ptr_reg];
    assign {q_ax, q_ay, q_az, q_mxy, q_mall, q_neg} = q_word;

    // control next state
    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_accept) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
        end else begin
            f_valid_reg <= f_valid_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            count_reg   <= count_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            f_ax_reg  <= mag(s_x_mm);
            f_ay_reg  <= mag(s_y_mm);
            f_az_reg  <= mag(s_z_mm);
            f_neg_reg <= {s_x_mm[COORD_BITS-1], s_y_mm[COORD_BITS-1], s_z_mm[COORD_BITS-1]};
        end
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= {f_ax_reg, f_ay_reg, f_az_reg, mxy, mall, f_neg_reg};
        end
    end

endmodule

// File: rtl/c2s_isqrt.sv
// ----------------------------------------------------------------------------
// c2s_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
module c2s_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [c2s_pkg::SQ_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [c2s_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]         out_side
);
    import c2s_pkg::*;

    localparam int STAGES = ROOT_W;

    logic [STAGES:0] v_reg;
    logic [SQ_W-1:0]   n_reg    [0:STAGES];
    logic [SQ_W-1:0]   r_reg    [0:STAGES];
    logic [SIDE_W-1:0] side_reg [0:STAGES];
    logic [SQ_W-1:0]   n_next   [0:STAGES-1];
    logic [SQ_W-1:0]   r_next   [0:STAGES-1];

    // one compare and subtract per stage
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            logic [SQ_W-1:0] bitv;
            logic [SQ_W-1:0] t;
            bitv = SQ_W'(1) << (2 * (STAGES - 1 - k));
            t    = r_reg[k] + bitv;
            if (n_reg[k] >= t) begin
                n_next[k] = n_reg[k] - t;
                r_next[k] = (r_reg[k] >> 1) + bitv;
            end else begin
                n_next[k] = n_reg[k];
                r_next[k] = r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STAGES-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]    <= in_rad;
            r_reg[0]    <= '0;
            side_reg[0] <= in_side;
            for (int k = 0; k < STAGES; k++) begin
                n_reg[k+1]    <= n_next[k];
                r_reg[k+1]    <= r_next[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_root  = r_reg[STAGES][ROOT_W-1:0];
    assign out_side  = side_reg[STAGES];

    // remainder of a finished root never exceeds twice the root
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (n_reg[STAGES] <= {r_reg[STAGES][SQ_W-2:0], 1'b0}))
        else $error("isqrt remainder out of bound");

endmodule

// File: rtl/c2s_cordic.sv
// ----------------------------------------------------------------------------
// c2s_cordic
// Pipelined vectoring CORDIC: first-quadrant atan2(b, a) in degrees, Q.20,
// one micro-rotation per stage, result clamped to 0..90 degrees.
// ----------------------------------------------------------------------------
module c2s_cordic #(
    parameter int SIDE_W = 1
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [c2s_pkg::NORM_W-1:0]       in_a,
    input  logic [c2s_pkg::NORM_W-1:0]       in_b,
    input  logic [SIDE_W-1:0]                in_side,
    output logic                             out_valid,
    output logic signed [c2s_pkg::ANG_W-1:0] out_angle,
    output logic [SIDE_W-1:0]                out_side
);
    import c2s_pkg::*;

    localparam int STEPS = CORDIC_STEPS;

    logic [STEPS+1:0]        v_reg;
    logic signed [CX_W-1:0]  x_reg    [0:STEPS];
    logic signed [CX_W-1:0]  y_reg    [0:STEPS];
    logic signed [ANG_W-1:0] z_reg    [0:STEPS];
    logic [SIDE_W-1:0]       side_reg [0:STEPS];
    logic [STEPS:0]          za_reg, zb_reg;
    logic signed [CX_W-1:0]  x_next   [0:STEPS-1];
    logic signed [CX_W-1:0]  y_next   [0:STEPS-1];
    logic signed [ANG_W-1:0] z_next   [0:STEPS-1];
    logic signed [ANG_W-1:0] ang_next;
    logic signed [ANG_W-1:0] out_angle_reg;
    logic [SIDE_W-1:0]       out_side_reg;

    // micro-rotations, arithmetic shifts round toward minus infinity
    always_comb begin
        for (int k = 0; k < STEPS; k++) begin
            if (!y_reg[k][CX_W-1]) begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k] + signed'(atan_q20(k));
            end else begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k] - signed'(atan_q20(k));
            end
        end
    end

    // axis cases, then clamp
    always_comb begin
        if (zb_reg[STEPS]) begin
            ang_next = '0;
        end else if (za_reg[STEPS]) begin
            ang_next = DEG90;
        end else if (z_reg[STEPS] < 0) begin
            ang_next = '0;
        end else if (z_reg[STEPS] > DEG90) begin
            ang_next = DEG90;
        end else begin
            ang_next = z_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[STEPS:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CX_W'(in_a);
            y_reg[0]    <= CX_W'(in_b);
            z_reg[0]    <= '0;
            side_reg[0] <= in_side;
            za_reg      <= {za_reg[STEPS-1:0], (in_a == '0)};
            zb_reg      <= {zb_reg[STEPS-1:0], (in_b == '0)};
            for (int k = 0; k < STEPS; k++) begin
                x_reg[k+1]    <= x_next[k];
                y_reg[k+1]    <= y_next[k];
                z_reg[k+1]    <= z_next[k];
                side_reg[k+1] <= side_reg[k];
            end
            out_angle_reg <= ang_next;
            out_side_reg  <= side_reg[STEPS];
        end
    end

    assign out_valid = v_reg[STEPS+1];
    assign out_angle = out_angle_reg;
    assign out_side  = out_side_reg;

    // quadrant angle stays within 0..90 degrees
    a_ang_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_angle_reg >= 0 && out_angle_reg <= DEG90))
        else $error("cordic angle outside first quadrant");

endmodule

// File: rtl/c2s_back.sv
// ----------------------------------------------------------------------------
// c2s_back
// Back end: squares and normalization, range and horizontal-norm roots,
// azimuth and elevation CORDICs, unfolding and rounding, output register.
// ----------------------------------------------------------------------------
module c2s_back #(
    parameter int COORD_BITS          = c2s_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRACTION_BITS = c2s_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     q_valid,
    output logic                                     q_ready,
    input  logic [COORD_BITS-1:0]                    q_ax,
    input  logic [COORD_BITS-1:0]                    q_ay,
    input  logic [COORD_BITS-1:0]                    q_az,
    input  logic [COORD_BITS-1:0]                    q_mxy,
    input  logic [COORD_BITS-1:0]                    q_mall,
    input  logic [2:0]                               q_neg,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [c2s_pkg::RANGE_WIDTH-1:0]          m_range_mm,
    output logic signed [c2s_pkg::AZIMUTH_WIDTH-1:0] m_azimuth_deg,
    output logic signed [c2s_pkg::ELEVATION_WIDTH-1:0] m_elevation_deg
);
    import c2s_pkg::*;

    localparam int SH = INT_FRAC - ANGLE_FRACTION_BITS;
    localparam logic [ANG_W-1:0] HALF = ANG_W'(1) << (SH - 1);
    localparam int EL_SIDE_W = 3 * NORM_W;
    localparam int AZ_SIDE_W = RANGE_WIDTH + 2;

    // round to nearest, ties away from zero
    function automatic logic [ANG_W-1:0] round_ang(input logic signed [ANG_W-1:0] v);
        logic [ANG_W-1:0] m;
        logic [ANG_W-1:0] r;
        m = v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
        r = (m + HALF) >> SH;
        return v[ANG_W-1] ? (~r + 1'b1) : r;
    endfunction

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic m_valid_reg, m_valid_next;

    // stage 1: squares, normalizing shifts
    logic [COORD_BITS-1:0]   ax1_reg, ay1_reg, az1_reg;
    logic [2*COORD_BITS-1:0] sx1_reg, sy1_reg, sz1_reg;
    logic [SHIFT_W-1:0]      sxy1_reg, sall1_reg;
    logic [2:0]              neg1_reg;
    // stage 2: range radicand, normalized operands
    logic [SQ_W-1:0]   rsum2_reg;
    logic [NORM_W-1:0] axn2_reg, ayn2_reg, ex2_reg, ey2_reg, ez2_reg;
    logic [2:0]        neg2_reg;
    // stage 3: horizontal squares
    logic [SQ_W-1:0]   rsum3_reg, px3_reg, py3_reg;
    logic [NORM_W-1:0] axn3_reg, ayn3_reg, ez3_reg;
    logic [2:0]        neg3_reg;
    // stage 4: horizontal radicand
    logic [SQ_W-1:0]   rsum4_reg, esum4_reg;
    logic [NORM_W-1:0] axn4_reg, ayn4_reg, ez4_reg;
    logic [2:0]        neg4_reg;

    logic                 rq_valid, eq_valid;
    logic [ROOT_W-1:0]    range_root, h_root;
    logic [2:0]           rq_neg;
    logic [EL_SIDE_W-1:0] eq_side;
    logic [NORM_W-1:0]    axn5, ayn5, ez5;

    logic                    ac_valid, ec_valid;
    logic signed [ANG_W-1:0] az_q, el_q;
    logic [AZ_SIDE_W-1:0]    ac_side;
    logic                    ec_side;
    logic [RANGE_WIDTH-1:0]  range_c;
    logic                    nx_c, ny_c;
    logic signed [ANG_W-1:0] az_u, az_s, el_s;

    logic [RANGE_WIDTH-1:0]            m_range_reg;
    logic signed [AZIMUTH_WIDTH-1:0]   m_azimuth_reg;
    logic signed [ELEVATION_WIDTH-1:0] m_elevation_reg;

    // whole back pipeline moves together when the output slot frees up
    assign en      = !m_valid_reg || m_ready;
    assign q_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= q_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // front stages of the datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg   <= q_ax;
            ay1_reg   <= q_ay;
            az1_reg   <= q_az;
            sx1_reg   <= q_ax * q_ax;
            sy1_reg   <= q_ay * q_ay;
            sz1_reg   <= q_az * q_az;
            sxy1_reg  <= norm_shift(bit_len(NORM_W'(q_mxy)));
            sall1_reg <= norm_shift(bit_len(NORM_W'(q_mall)));
            neg1_reg  <= q_neg;

            rsum2_reg <= SQ_W'(sx1_reg) + SQ_W'(sy1_reg) + SQ_W'(sz1_reg);
            axn2_reg  <= NORM_W'(ax1_reg) << sxy1_reg;
            ayn2_reg  <= NORM_W'(ay1_reg) << sxy1_reg;
            ex2_reg   <= NORM_W'(ax1_reg) << sall1_reg;
            ey2_reg   <= NORM_W'(ay1_reg) << sall1_reg;
            ez2_reg   <= NORM_W'(az1_reg) << sall1_reg;
            neg2_reg  <= neg1_reg;

            rsum3_reg <= rsum2_reg;
            px3_reg   <= ex2_reg * ex2_reg;
            py3_reg   <= ey2_reg * ey2_reg;
            axn3_reg  <= axn2_reg;
            ayn3_reg  <= ayn2_reg;
            ez3_reg   <= ez2_reg;
            neg3_reg  <= neg2_reg;

            rsum4_reg <= rsum3_reg;
            esum4_reg <= px3_reg + py3_reg;
            axn4_reg  <= axn3_reg;
            ayn4_reg  <= ayn3_reg;
            ez4_reg   <= ez3_reg;
            neg4_reg  <= neg3_reg;
        end
    end

    // range root and horizontal norm, side by side
    c2s_isqrt #(.SIDE_W(3)) u_range_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .in_rad   (rsum4_reg),
        .in_side  (neg4_reg),
        .out_valid(rq_valid),
        .out_root (range_root),
        .out_side (rq_neg)
    );

    c2s_isqrt #(.SIDE_W(EL_SIDE_W)) u_horiz_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .in_rad   (esum4_reg),
        .in_side  ({axn4_reg, ayn4_reg, ez4_reg}),
        .out_valid(eq_valid),
        .out_root (h_root),
        .out_side (eq_side)
    );

    assign {axn5, ayn5, ez5} = eq_side;

    // azimuth and elevation angles
    c2s_cordic #(.SIDE_W(AZ_SIDE_W)) u_az_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rq_valid && eq_valid),
        .in_a     (axn5),
        .in_b     (ayn5),
        .in_side  ({range_root[RANGE_WIDTH-1:0], rq_neg[2], rq_neg[1]}),
        .out_valid(ac_valid),
        .out_angle(az_q),
        .out_side (ac_side)
    );

    c2s_cordic #(.SIDE_W(1)) u_el_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (rq_valid && eq_valid),
        .in_a     (NORM_W'(h_root)),
        .in_b     (ez5),
        .in_side  (rq_neg[0]),
        .out_valid(ec_valid),
        .out_angle(el_q),
        .out_side (ec_side)
    );

    // unfold quadrants by sign
    always_comb begin
        {range_c, nx_c, ny_c} = ac_side;
        az_u = nx_c ? (DEG180 - az_q) : az_q;
        az_s = ny_c ? -az_u : az_u;
        el_s = ec_side ? -el_q : el_q;
        m_valid_next = en ? ac_valid : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_range_reg     <= range_c;
            m_azimuth_reg   <= AZIMUTH_WIDTH'(round_ang(az_s));
            m_elevation_reg <= ELEVATION_WIDTH'(round_ang(el_s));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_range_mm      = m_range_reg;
    assign m_azimuth_deg   = m_azimuth_reg;
    assign m_elevation_deg = m_elevation_reg;

    // parallel branches must stay in lockstep
    a_sqrt_align: assert property (@(posedge aclk) disable iff (!aresetn)
        rq_valid == eq_valid)
        else $error("square root branches out of step");

    a_cordic_align: assert property (@(posedge aclk) disable iff (!aresetn)
        ac_valid == ec_valid)
        else $error("cordic branches out of step");

    // a stalled output item is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_range_reg)))
        else $error("output item lost under stall");

endmodule

// File: rtl/cartesian_to_spherical_point.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical_point
// Converts one lidar point (x, y, z in mm) to range, azimuth and elevation.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  input   | s_valid s_ready s_x_mm s_y_mm s_z_mm   | in
//  result  | m_valid m_ready m_range_mm             | out
//          | m_azimuth_deg m_elevation_deg          |
//
//  One point per clock sustained while m_ready stays high; every stage is pipelined.
//  From the accepting edge to m_valid an item passes 66 registers: the first
//  (classify) loaded at the accepting edge, then the queue, four square/normalize
//  stages, 33 square-root stages, 26 CORDIC stages and the output register.
//  Synchronous active-low reset clears all valid flags; data is not reset.
//  An output stall freezes the back pipeline; the two-entry queue lets the
//  front keep taking items until it fills.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_point #(
    parameter int COORD_BITS          = c2s_pkg::COORD_BITS_DEF,
    parameter int ANGLE_FRACTION_BITS = c2s_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       s_valid,
    output logic                                       s_ready,
    input  logic signed [COORD_BITS-1:0]               s_x_mm,
    input  logic signed [COORD_BITS-1:0]               s_y_mm,
    input  logic signed [COORD_BITS-1:0]               s_z_mm,
    output logic                                       m_valid,
    input  logic                                       m_ready,
    output logic [c2s_pkg::RANGE_WIDTH-1:0]            m_range_mm,
    output logic signed [c2s_pkg::AZIMUTH_WIDTH-1:0]   m_azimuth_deg,
    output logic signed [c2s_pkg::ELEVATION_WIDTH-1:0] m_elevation_deg
);
    import c2s_pkg::*;

    logic                  q_valid, q_ready;
    logic [COORD_BITS-1:0] q_ax, q_ay, q_az, q_mxy, q_mall;
    logic [2:0]            q_neg;

    c2s_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_x_mm (s_x_mm),
        .s_y_mm (s_y_mm),
        .s_z_mm (s_z_mm),
        .q_valid(q_valid),
        .q_ready(q_ready),
        .q_ax   (q_ax),
        .q_ay   (q_ay),
        .q_az   (q_az),
        .q_mxy  (q_mxy),
        .q_mall (q_mall),
        .q_neg  (q_neg)
    );

    c2s_back #(
        .COORD_BITS         (COORD_BITS),
        .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_ax           (q_ax),
        .q_ay           (q_ay),
        .q_az           (q_az),
        .q_mxy          (q_mxy),
        .q_mall         (q_mall),
        .q_neg          (q_neg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_range_mm     (m_range_mm),
        .m_azimuth_deg  (m_azimuth_deg),
        .m_elevation_deg(m_elevation_deg)
    );

endmodule
